// File: hw/rtl/msff_pkg.sv
`timescale 1ns / 1ps

package msff_pkg;

    localparam int Q_W      = 24;
    localparam int QMAG_W   = 23;
    localparam int LEN_W    = 20;
    localparam int CON_W    = 32;
    localparam int RAD_W    = 21;
    localparam int VOL_W    = 58;
    localparam int AMP_W    = 64;
    localparam int OUT63_W  = 63;
    localparam int TDATA_W  = 192;
    localparam int PADDR_W  = 5;

    localparam int TRIG_ITER_DEF = 24;
    localparam int RED_STEPS     = 14;
    localparam int DIV_QUO_W     = 33;
    localparam int LANE_LAT_FIXED = 14 + RED_STEPS + 2 * DIV_QUO_W;

    localparam longint ONE_Q30     = 64'd1073741824;
    localparam longint TWO_PI_Q28  = 64'd1686629713;
    localparam longint CORDIC_GAIN = 64'd652032874;
    localparam longint VOL_K_Q28   = 64'd1124419809;

    localparam longint HC_10        = 64'd107374182;
    localparam longint HC_280       = 64'd3834792;
    localparam longint HC_15120     = 64'd71015;
    localparam longint HC_1330560   = 64'd807;
    localparam longint HC_172972800 = 64'd6;

    typedef enum logic [2:0] {
        REG_CORE_RADIUS  = 3'd0,
        REG_SHELL1_THICK = 3'd1,
        REG_SHELL2_THICK = 3'd2,
        REG_SHELL3_THICK = 3'd3,
        REG_CONTRAST_CORE = 3'd4,
        REG_CONTRAST_SH1 = 3'd5,
        REG_CONTRAST_SH2 = 3'd6,
        REG_CONTRAST_SH3 = 3'd7
    } reg_idx_t;

    localparam logic [30:0] ATAN_TAB [0:9] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149
    };

    function automatic logic [30:0] atan_q30(input int i);
        logic [30:0] r;
        if (i < 10)
        begin
            r = ATAN_TAB[i];
        end
        else if (i <= 30)
        begin
            r = 31'd1 << (30 - i);
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [95:0] v);
        logic signed [63:0] r;
        if (v[95:63] == '0 || v[95:63] == '1)
        begin
            r = v[63:0];
        end
        else if (v[95])
        begin
            r = {1'b1, 63'd0};
        end
        else
        begin
            r = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/msff_lane.sv
`timescale 1ns / 1ps

module msff_lane #(
    parameter int TRIG_ITERATIONS = msff_pkg::TRIG_ITER_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [msff_pkg::QMAG_W-1:0]         q,
    input  logic [msff_pkg::RAD_W-1:0]          r,
    output logic signed [msff_pkg::AMP_W-1:0]   amp,
    output logic [msff_pkg::VOL_W-1:0]          vol
);
    import msff_pkg::*;

    localparam int QW = DIV_QUO_W;
    localparam int NI = TRIG_ITERATIONS;

    typedef struct packed {
        logic        series;
        logic [29:0] xr;
        logic [30:0] p;
        logic [57:0] v;
        logic        flip;
        logic        neg;
    } carry_t;

    function automatic logic [30:0] horner(input longint c, input logic [30:0] p,
                                           input logic [29:0] u);
        logic [61:0] t;
        t = (62'(p) * 62'(u)) >> 30;
        return 31'(62'(c) - t);
    endfunction

    // front: x = qR, series terms and volume
    logic [43:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg, x6_reg, x7_reg;
    logic [41:0] r2_1_reg;
    logic [20:0] r1_reg;
    logic        sm2_reg, sm3_reg, sm4_reg, sm5_reg, sm6_reg, sm7_reg;
    logic [29:0] xr2_reg, xr3_reg, xr4_reg, xr5_reg, xr6_reg, xr7_reg;
    logic [29:0] u2_reg, u3_reg, u4_reg, u5_reg, u6_reg;
    logic [52:0] r3lo_reg;
    logic [30:0] r3hi_reg;
    logic [62:0] r3_reg;
    logic [62:0] vlo_reg;
    logic [61:0] vhi_reg;
    logic [57:0] v5_reg, v6_reg, v7_reg;
    logic [30:0] p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= 44'(q) * 44'(r);
            r2_1_reg <= 42'(r) * 42'(r);
            r1_reg   <= r;

            x2_reg   <= x1_reg;
            sm2_reg  <= (x1_reg[43:28] == '0);
            xr2_reg  <= x1_reg[43:14];
            u2_reg   <= 30'((56'(x1_reg[27:0]) * 56'(x1_reg[27:0])) >> 26);
            r3lo_reg <= 53'(r2_1_reg[31:0]) * 53'(r1_reg);
            r3hi_reg <= 31'(r2_1_reg[41:32]) * 31'(r1_reg);

            x3_reg  <= x2_reg;
            sm3_reg <= sm2_reg;
            xr3_reg <= xr2_reg;
            u3_reg  <= u2_reg;
            r3_reg  <= 63'(r3lo_reg) + (63'(r3hi_reg) << 32);
            p3_reg  <= horner(HC_1330560, 31'(HC_172972800), u2_reg);

            x4_reg  <= x3_reg;
            sm4_reg <= sm3_reg;
            xr4_reg <= xr3_reg;
            u4_reg  <= u3_reg;
            vlo_reg <= 63'(r3_reg[31:0]) * 63'(VOL_K_Q28);
            vhi_reg <= 62'(r3_reg[62:32]) * 62'(VOL_K_Q28);
            p4_reg  <= horner(HC_15120, p3_reg, u3_reg);

            x5_reg  <= x4_reg;
            sm5_reg <= sm4_reg;
            xr5_reg <= xr4_reg;
            u5_reg  <= u4_reg;
            v5_reg  <= 58'((94'(vlo_reg) + (94'(vhi_reg) << 32)) >> 36);
            p5_reg  <= horner(HC_280, p4_reg, u4_reg);

            x6_reg  <= x5_reg;
            sm6_reg <= sm5_reg;
            xr6_reg <= xr5_reg;
            u6_reg  <= u5_reg;
            v6_reg  <= v5_reg;
            p6_reg  <= horner(HC_10, p5_reg, u5_reg);

            x7_reg  <= x6_reg;
            sm7_reg <= sm6_reg;
            xr7_reg <= xr6_reg;
            v7_reg  <= v6_reg;
            p7_reg  <= horner(ONE_Q30, p6_reg, u6_reg);
        end
    end

    // angle reduction mod 2pi, one quotient bit per stage
    logic [43:0] red_rem_reg [0:RED_STEPS-1];
    carry_t      red_c_reg   [0:RED_STEPS-1];
    carry_t      front_c;

    always_comb
    begin
        front_c        = '0;
        front_c.series = sm7_reg;
        front_c.xr     = xr7_reg;
        front_c.p      = p7_reg;
        front_c.v      = v7_reg;
    end

    for (genvar j = 0; j < RED_STEPS; j++)
    begin : g_red
        localparam logic [43:0] MODC = 44'(TWO_PI_Q28) << (RED_STEPS - 1 - j);
        logic [43:0] src;
        carry_t      src_c;
        if (j == 0)
        begin : g_first
            assign src   = x7_reg;
            assign src_c = front_c;
        end
        else
        begin : g_next
            assign src   = red_rem_reg[j-1];
            assign src_c = red_c_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                red_rem_reg[j] <= (src >= MODC) ? src - MODC : src;
                red_c_reg[j]   <= src_c;
            end
        end
    end

    // fold into [-pi/2, pi/2]
    localparam logic signed [34:0] PI_H = 35'(TWO_PI_Q28);
    localparam logic signed [34:0] PI_1 = 35'(2 * TWO_PI_Q28);
    localparam logic signed [34:0] PI_2 = 35'(4 * TWO_PI_Q28);

    logic signed [34:0] fa;
    carry_t             fc;
    logic signed [34:0] fold_z_reg;
    carry_t             fold_c_reg;

    always_comb
    begin
        fc = red_c_reg[RED_STEPS-1];
        fa = $signed({2'b00, red_rem_reg[RED_STEPS-1][30:0], 2'b00});
        fc.flip = 1'b0;
        if (fa > PI_1)
        begin
            fa = fa - PI_2;
        end
        if (fa > PI_H)
        begin
            fa = fa - PI_1;
            fc.flip = 1'b1;
        end
        else if (fa < -PI_H)
        begin
            fa = fa + PI_1;
            fc.flip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_z_reg <= fa;
            fold_c_reg <= fc;
        end
    end

    // CORDIC rotation stages
    logic signed [33:0] cx_reg [0:NI-1];
    logic signed [33:0] cy_reg [0:NI-1];
    logic signed [34:0] cz_reg [0:NI-1];
    carry_t             cc_reg [0:NI-1];

    for (genvar i = 0; i < NI; i++)
    begin : g_cordic
        localparam logic signed [34:0] ANG = 35'(atan_q30(i));
        logic signed [33:0] sx, sy;
        logic signed [34:0] sz;
        carry_t             sc;
        if (i == 0)
        begin : g_first
            assign sx = 34'(CORDIC_GAIN);
            assign sy = '0;
            assign sz = fold_z_reg;
            assign sc = fold_c_reg;
        end
        else
        begin : g_next
            assign sx = cx_reg[i-1];
            assign sy = cy_reg[i-1];
            assign sz = cz_reg[i-1];
            assign sc = cc_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sz >= 0)
                begin
                    cx_reg[i] <= sx - (sy >>> i);
                    cy_reg[i] <= sy + (sx >>> i);
                    cz_reg[i] <= sz - ANG;
                end
                else
                begin
                    cx_reg[i] <= sx + (sy >>> i);
                    cy_reg[i] <= sy - (sx >>> i);
                    cz_reg[i] <= sz + ANG;
                end
                cc_reg[i] <= sc;
            end
        end
    end

    // N = sin - x cos
    logic signed [63:0] n1_prod_reg;
    logic signed [33:0] n1_y_reg;
    carry_t             n1_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_prod_reg <= 64'($signed({1'b0, cc_reg[NI-1].xr})) * 64'(cx_reg[NI-1]);
            n1_y_reg    <= cy_reg[NI-1];
            n1_c_reg    <= cc_reg[NI-1];
        end
    end

    logic signed [63:0] prodf;
    logic signed [34:0] sn;
    logic signed [50:0] nv;
    logic [49:0]        nabs;
    carry_t             n2c;
    logic [63:0]        n2_rem_reg;
    carry_t             n2_c_reg;

    always_comb
    begin
        n2c   = n1_c_reg;
        prodf = n1_c_reg.flip ? -n1_prod_reg : n1_prod_reg;
        sn    = n1_c_reg.flip ? -35'(n1_y_reg) : 35'(n1_y_reg);
        nv    = 51'(sn) - 51'(prodf >>> 14);
        nabs  = nv[50] ? 50'(-nv) : 50'(nv);
        n2c.neg = nv[50];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_rem_reg <= {nabs, 14'd0};
            n2_c_reg   <= n2c;
        end
    end

    // first divider: N * 2^14 / xr
    logic [63:0]   d1_rem_reg [0:QW-1];
    logic [QW-1:0] d1_quo_reg [0:QW-1];
    carry_t        d1_c_reg   [0:QW-1];

    for (genvar j = 0; j < QW; j++)
    begin : g_div1
        localparam int SH = QW - 1 - j;
        logic [63:0]   src;
        logic [QW-1:0] sq;
        carry_t        src_c;
        logic          take;
        if (j == 0)
        begin : g_first
            assign src   = n2_rem_reg;
            assign sq    = '0;
            assign src_c = n2_c_reg;
        end
        else
        begin : g_next
            assign src   = d1_rem_reg[j-1];
            assign sq    = d1_quo_reg[j-1];
            assign src_c = d1_c_reg[j-1];
        end
        assign take = (src >> SH) >= 64'(src_c.xr);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_rem_reg[j] <= take ? src - (64'(src_c.xr) << SH) : src;
                d1_quo_reg[j] <= {sq[QW-2:0], take};
                d1_c_reg[j]   <= src_c;
            end
        end
    end

    logic [60:0] dq_rem_reg;
    logic [59:0] dq_div_reg;
    carry_t      dq_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_rem_reg <= {d1_quo_reg[QW-1], 28'd0};
            dq_div_reg <= 60'(d1_c_reg[QW-1].xr) * 60'(d1_c_reg[QW-1].xr);
            dq_c_reg   <= d1_c_reg[QW-1];
        end
    end

    // second divider: q1 * 2^28 / xr^2
    logic [60:0]   d2_rem_reg [0:QW-1];
    logic [59:0]   d2_div_reg [0:QW-1];
    logic [QW-1:0] d2_quo_reg [0:QW-1];
    carry_t        d2_c_reg   [0:QW-1];

    for (genvar j = 0; j < QW; j++)
    begin : g_div2
        localparam int SH = QW - 1 - j;
        logic [60:0]   src;
        logic [59:0]   sd;
        logic [QW-1:0] sq;
        carry_t        src_c;
        logic          take;
        if (j == 0)
        begin : g_first
            assign src   = dq_rem_reg;
            assign sd    = dq_div_reg;
            assign sq    = '0;
            assign src_c = dq_c_reg;
        end
        else
        begin : g_next
            assign src   = d2_rem_reg[j-1];
            assign sd    = d2_div_reg[j-1];
            assign sq    = d2_quo_reg[j-1];
            assign src_c = d2_c_reg[j-1];
        end
        assign take = (src >> SH) >= 61'(sd);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d2_rem_reg[j] <= take ? src - (61'(sd) << SH) : src;
                d2_div_reg[j] <= sd;
                d2_quo_reg[j] <= {sq[QW-2:0], take};
                d2_c_reg[j]   <= src_c;
            end
        end
    end

    // shape factor select and A = V * g
    logic [35:0]        g3;
    logic signed [35:0] g_reg;
    logic [57:0]        g_v_reg;
    logic signed [68:0] m1_lo_reg;
    logic signed [62:0] m1_hi_reg;
    logic [57:0]        m1_v_reg;
    logic signed [95:0] m2_full;
    logic signed [AMP_W-1:0] amp_reg;
    logic [VOL_W-1:0]   vol_reg;

    assign g3 = (36'(d2_quo_reg[QW-1]) << 1) + 36'(d2_quo_reg[QW-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (d2_c_reg[QW-1].series)
            begin
                g_reg <= $signed(36'(d2_c_reg[QW-1].p));
            end
            else
            begin
                g_reg <= d2_c_reg[QW-1].neg ? -$signed(g3) : $signed(g3);
            end
            g_v_reg <= d2_c_reg[QW-1].v;

            m1_lo_reg <= 69'($signed({1'b0, g_v_reg[31:0]})) * 69'(g_reg);
            m1_hi_reg <= 63'($signed({1'b0, g_v_reg[57:32]})) * 63'(g_reg);
            m1_v_reg  <= g_v_reg;

            amp_reg <= sat64(m2_full >>> 30);
            vol_reg <= m1_v_reg;
        end
    end

    assign m2_full = (96'(m1_hi_reg) <<< 32) + 96'(m1_lo_reg);

    assign amp = amp_reg;
    assign vol = vol_reg;

endmodule

// File: hw/rtl/multishell_sphere_form_factor_top.sv
`timescale 1ns / 1ps

// Three-shell sphere form factor. Each request carries one q (Q3.20 per nm) and
// yields one result: amplitude, intensity and outer volume in Q.16, with a
// bad-argument flag in tuser. Fully pipelined: one request per clock while the
// output is not stalled. Each of the four radius lanes holds the CORDIC stages
// and the two bit-per-stage dividers.
// A stall on the output freezes the whole pipeline. Radii and contrasts come
// from the APB registers and must only change while no request is in flight.

module multishell_sphere_form_factor_top #(
    parameter int TRIG_ITERATIONS = msff_pkg::TRIG_ITER_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msff_pkg::Q_W-1:0]        s_tdata,   // q
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msff_pkg::TDATA_W-1:0]    m_tdata,   // amplitude, intensity, volume
    output logic [0:0]                      m_tuser,   // bad_argument
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msff_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import msff_pkg::*;

    localparam int LANE_LAT = LANE_LAT_FIXED + TRIG_ITERATIONS;
    localparam int TOTAL    = LANE_LAT + 6;

    // configuration
    logic signed [LEN_W-1:0] core_radius_reg, shell1_reg, shell2_reg, shell3_reg;
    logic signed [CON_W-1:0] con_core_reg, con_sh1_reg, con_sh2_reg, con_sh3_reg;
    reg_idx_t                ridx;

    assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_radius_reg <= '0;
            shell1_reg      <= '0;
            shell2_reg      <= '0;
            shell3_reg      <= '0;
            con_core_reg    <= '0;
            con_sh1_reg     <= '0;
            con_sh2_reg     <= '0;
            con_sh3_reg     <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                REG_CORE_RADIUS:   core_radius_reg <= pwdata[LEN_W-1:0];
                REG_SHELL1_THICK:  shell1_reg      <= pwdata[LEN_W-1:0];
                REG_SHELL2_THICK:  shell2_reg      <= pwdata[LEN_W-1:0];
                REG_SHELL3_THICK:  shell3_reg      <= pwdata[LEN_W-1:0];
                REG_CONTRAST_CORE: con_core_reg    <= pwdata;
                REG_CONTRAST_SH1:  con_sh1_reg     <= pwdata;
                REG_CONTRAST_SH2:  con_sh2_reg     <= pwdata;
                REG_CONTRAST_SH3:  con_sh3_reg     <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_CORE_RADIUS:   prdata = 32'(core_radius_reg);
            REG_SHELL1_THICK:  prdata = 32'(shell1_reg);
            REG_SHELL2_THICK:  prdata = 32'(shell2_reg);
            REG_SHELL3_THICK:  prdata = 32'(shell3_reg);
            REG_CONTRAST_CORE: prdata = con_core_reg;
            REG_CONTRAST_SH1:  prdata = con_sh1_reg;
            REG_CONTRAST_SH2:  prdata = con_sh2_reg;
            REG_CONTRAST_SH3:  prdata = con_sh3_reg;
        endcase
    end

    // pipeline control
    logic en;
    logic vld_reg [0:TOTAL];
    logic bad_reg [0:TOTAL-1];

    assign en       = !vld_reg[TOTAL] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= TOTAL; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= TOTAL; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // input stage: radii and argument check
    logic [QMAG_W-1:0] q0_reg;
    logic [RAD_W-1:0]  rad_reg [0:3];
    logic [RAD_W-1:0]  rad1, rad2, rad3;

    assign rad1 = RAD_W'(core_radius_reg[LEN_W-2:0]) + RAD_W'(shell1_reg[LEN_W-2:0]);
    assign rad2 = rad1 + RAD_W'(shell2_reg[LEN_W-2:0]);
    assign rad3 = rad2 + RAD_W'(shell3_reg[LEN_W-2:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg     <= s_tdata[QMAG_W-1:0];
            rad_reg[0] <= RAD_W'(core_radius_reg[LEN_W-2:0]);
            rad_reg[1] <= rad1;
            rad_reg[2] <= rad2;
            rad_reg[3] <= rad3;
            bad_reg[0] <= s_tdata[Q_W-1] | core_radius_reg[LEN_W-1] | shell1_reg[LEN_W-1]
                          | shell2_reg[LEN_W-1] | shell3_reg[LEN_W-1];
            for (int k = 1; k < TOTAL; k++)
            begin
                bad_reg[k] <= bad_reg[k-1];
            end
        end
    end

    // radius lanes
    logic signed [AMP_W-1:0] lane_amp [0:3];
    logic [VOL_W-1:0]        lane_vol;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        if (k == 3)
        begin : g_outer
            msff_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane (
                .clk (clk),
                .en  (en),
                .q   (q0_reg),
                .r   (rad_reg[k]),
                .amp (lane_amp[k]),
                .vol (lane_vol)
            );
        end
        else
        begin : g_inner
            msff_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane (
                .clk (clk),
                .en  (en),
                .q   (q0_reg),
                .r   (rad_reg[k]),
                .amp (lane_amp[k]),
                .vol ()
            );
        end
    end

    // contrast weighting
    logic signed [CON_W:0] dcon [0:3];

    assign dcon[0] = (CON_W+1)'(con_core_reg) - (CON_W+1)'(con_sh1_reg);
    assign dcon[1] = (CON_W+1)'(con_sh1_reg) - (CON_W+1)'(con_sh2_reg);
    assign dcon[2] = (CON_W+1)'(con_sh2_reg) - (CON_W+1)'(con_sh3_reg);
    assign dcon[3] = (CON_W+1)'(con_sh3_reg);

    logic signed [65:0] c1_lo_reg [0:3];
    logic signed [64:0] c1_hi_reg [0:3];
    logic signed [98:0] c2_reg    [0:3];
    logic signed [98:0] acc_reg;
    logic signed [AMP_W-1:0] amp4_reg, amp5_reg;
    logic [63:0]        sq_ll_reg, sq_lh_reg, sq_hl_reg, sq_hh_reg;
    logic [VOL_W-1:0]   vol_d_reg [1:5];
    logic [AMP_W-1:0]   mag;
    logic [127:0]       sq;
    logic [111:0]       sq_sh;

    logic signed [AMP_W-1:0]  amp_o_reg;
    logic [OUT63_W-1:0]       int_o_reg;
    logic [OUT63_W-1:0]       vol_o_reg;
    logic                     bad_o_reg;

    assign mag   = amp4_reg[AMP_W-1] ? AMP_W'(-amp4_reg) : AMP_W'(amp4_reg);
    assign sq    = (128'(sq_hh_reg) << 64) + (128'(sq_lh_reg) << 32)
                   + (128'(sq_hl_reg) << 32) + 128'(sq_ll_reg);
    assign sq_sh = 112'(sq >> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                c1_lo_reg[k] <= 66'(dcon[k]) * 66'($signed({1'b0, lane_amp[k][31:0]}));
                c1_hi_reg[k] <= 65'(dcon[k]) * 65'($signed(lane_amp[k][63:32]));
                c2_reg[k]    <= (99'(c1_hi_reg[k]) <<< 32) + 99'(c1_lo_reg[k]);
            end
            acc_reg  <= c2_reg[0] + c2_reg[1] + c2_reg[2] + c2_reg[3];
            amp4_reg <= sat64(96'(acc_reg >>> 24));

            sq_ll_reg <= 64'(mag[31:0]) * 64'(mag[31:0]);
            sq_lh_reg <= 64'(mag[31:0]) * 64'(mag[63:32]);
            sq_hl_reg <= 64'(mag[63:32]) * 64'(mag[31:0]);
            sq_hh_reg <= 64'(mag[63:32]) * 64'(mag[63:32]);
            amp5_reg  <= amp4_reg;

            vol_d_reg[1] <= lane_vol;
            for (int k = 2; k <= 5; k++)
            begin
                vol_d_reg[k] <= vol_d_reg[k-1];
            end

            bad_o_reg <= bad_reg[TOTAL-1];
            if (bad_reg[TOTAL-1])
            begin
                amp_o_reg <= '0;
                int_o_reg <= '0;
                vol_o_reg <= '0;
            end
            else
            begin
                amp_o_reg <= amp5_reg;
                int_o_reg <= (sq_sh[111:63] != '0) ? {OUT63_W{1'b1}} : sq_sh[62:0];
                vol_o_reg <= OUT63_W'(vol_d_reg[5]);
            end
        end
    end

    assign m_tdata = {2'b00, vol_o_reg, int_o_reg, amp_o_reg};
    assign m_tuser = bad_o_reg;

endmodule
